[rtl/c8x_pkg.sv]
// Shared types, constants and the font table of the CHIP-8 executor.
// Depends on nothing; the ALU and the top level import it.
package c8x_pkg;

  localparam logic [11:0] START_PC  = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam int          FONT_LEN  = 80;
  localparam logic [3:0]  VF_IDX    = 4'hF;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_EXEC     = 2'd1,
    OP_READ_ROW = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  // Top nibble of an instruction.
  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SE   = 4'h3;
  localparam logic [3:0] OPC_SNE  = 4'h4;
  localparam logic [3:0] OPC_SEV  = 4'h5;
  localparam logic [3:0] OPC_LD   = 4'h6;
  localparam logic [3:0] OPC_ADD  = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNEV = 4'h9;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_JPV  = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [15:0] INSN_CLS = 16'h00E0;
  localparam logic [15:0] INSN_RET = 16'h00EE;

  // Low nibble of the 8XYN group.
  localparam logic [3:0] A8_MOV = 4'h0;
  localparam logic [3:0] A8_OR  = 4'h1;
  localparam logic [3:0] A8_AND = 4'h2;
  localparam logic [3:0] A8_XOR = 4'h3;
  localparam logic [3:0] A8_ADD = 4'h4;
  localparam logic [3:0] A8_SUB = 4'h5;
  localparam logic [3:0] A8_SHR = 4'h6;
  localparam logic [3:0] A8_RSB = 4'h7;
  localparam logic [3:0] A8_SHL = 4'hE;

  // Low byte of the FXNN group.
  localparam logic [7:0] FX_GET_DT = 8'h07;
  localparam logic [7:0] FX_SET_DT = 8'h15;
  localparam logic [7:0] FX_SET_ST = 8'h18;
  localparam logic [7:0] FX_ADD_I  = 8'h1E;
  localparam logic [7:0] FX_FONT   = 8'h29;
  localparam logic [7:0] FX_BCD    = 8'h33;
  localparam logic [7:0] FX_STORE  = 8'h55;
  localparam logic [7:0] FX_LOAD   = 8'h65;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } item_t;

  typedef struct packed {
    logic [11:0] pc_after;
    logic [15:0] instruction_word;
    logic [7:0]  flag_value;
    logic        screen_changed;
    logic        stack_error;
    logic [63:0] display_row;
  } result_t;

  typedef struct packed {
    logic shift_copies_vy;
  } cfg_t;

  typedef enum logic [2:0] {
    ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_F0, S_F1, S_F2, S_RX, S_RY, S_EXEC, S_RET, S_CLR,
    S_DRAWA, S_DRAWB, S_BCD, S_STORE, S_LOADA, S_LOADB, S_ROW, S_DONE
  } state_t;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Reset content of main memory at one address.
  function automatic logic [7:0] font_byte(input logic [11:0] addr);
    logic [11:0] off;
    off = addr - FONT_BASE;
    if (addr >= FONT_BASE && off < 12'(FONT_LEN)) begin
      font_byte = FONT[off[6:0]];
    end else begin
      font_byte = 8'h00;
    end
  endfunction

endpackage

[rtl/c8x_chan_if.sv]
// Valid/ready channel interface used for items, results and configuration.
// The payload type is a parameter.
interface c8x_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/c8x_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for main memory and the return stack.
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/c8x_alu.sv]
// Shared 8-bit arithmetic, logic, shift and compare unit of the executor.
// Depends on c8x_pkg for the request and response types.
module c8x_alu (
  input  c8x_pkg::alu_req_t req,
  output c8x_pkg::alu_rsp_t rsp
);
  import c8x_pkg::*;

  logic [8:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    rsp.eq = (req.a == req.b);
    unique case (req.op)
      ALU_PASS: begin rsp.res = req.b;          rsp.flag = 1'b0; end
      ALU_OR:   begin rsp.res = req.a | req.b;  rsp.flag = 1'b0; end
      ALU_AND:  begin rsp.res = req.a & req.b;  rsp.flag = 1'b0; end
      ALU_XOR:  begin rsp.res = req.a ^ req.b;  rsp.flag = 1'b0; end
      ALU_ADD:  begin rsp.res = sum[7:0];       rsp.flag = sum[8]; end
      ALU_SUB:  begin rsp.res = req.a - req.b;  rsp.flag = (req.a >= req.b); end
      ALU_SHR:  begin rsp.res = req.a >> 1;     rsp.flag = req.a[0]; end
      ALU_SHL:  begin rsp.res = req.a << 1;     rsp.flag = req.a[7]; end
      default:  begin rsp.res = req.b;          rsp.flag = 1'b0; end
    endcase
  end
endmodule

[rtl/chip8_instruction_executor_unit.sv]
// Top level of the CHIP-8 instruction executor: sequencer, registers, display.
// Depends on c8x_pkg, c8x_chan_if, c8x_ram and c8x_alu.
//
//  channel  | dir | payload                                   | accepted when
//  ---------+-----+-------------------------------------------+---------------------
//  items    | in  | operation, address, data, random, row     | valid & ready
//  results  | out | pc, word, VF, changed, stack error, row   | valid & ready
//  cfg      | in  | shift_copies_vy                           | valid & ready (always)
//
// After reset a clearing pass over all 4096 addresses loads the font and zeroes
// main memory; items are held off meanwhile, configuration words are taken.
// A load item writes its byte on acceptance; a row read latches one display row; an
// instruction fetches two bytes, reads Vx and Vy, executes, then its loop: return
// loads the PC, clear wipes all 32 rows, draw reads and writes each sprite row, BCD
// writes three digits, store writes V0..VX to memory, load reads bytes into V0..VX.
// One item is worked at a time; a result waits in the output register while the
// next item is accepted, and the block stalls in its last step if it is still taken.
module chip8_instruction_executor_unit #(
  parameter int STACK_DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  c8x_chan_if.sink    items,
  c8x_chan_if.source  results,
  c8x_chan_if.sink    cfg
);
  import c8x_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  state_t state, state_next;

  logic [11:0]    init_cnt;
  logic [4:0]     cnt;
  logic [7:0]     rnd_q;
  logic [4:0]     rowsel_q;
  logic [15:0]    word_q;
  logic [7:0]     vx_q, vy_q;
  logic [11:0]    pc;
  logic [15:0]    idx;
  logic [SPW-1:0] sp;
  logic [7:0]     dt;
  logic           shift_vy;
  logic [7:0]     v [16];
  logic [63:0]    frame [32];
  logic           changed, serr, hit;
  logic [63:0]    row_q;
  logic [11:0]    bcd_q;
  logic           out_valid;
  result_t        out_data;

  logic [3:0]  opc, x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;

  logic           mem_we;
  logic [11:0]    mem_waddr, mem_raddr, loop_addr;
  logic [7:0]     mem_wdata, mem_rd;
  logic [3:0]     v_ra;
  logic [7:0]     v_rd;
  logic [4:0]     frame_ra;
  logic [63:0]    frame_rd;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [11:0]    stk_rd;
  alu_req_t       alu_req;
  alu_rsp_t       alu_rsp;

  logic [63:0]  sprite, mask, overlap;
  logic [127:0] rot;
  logic [7:0]   shsrc;
  logic [3:0]   bcd_h, bcd_t, bcd_o;
  logic [7:0]   bcd_rem;
  logic [14:0]  bcd_prod;
  logic         last_row;

  assign opc = word_q[15:12];
  assign x   = word_q[11:8];
  assign y   = word_q[7:4];
  assign n   = word_q[3:0];
  assign nn  = word_q[7:0];
  assign nnn = word_q[11:0];

  assign items.ready   = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  assign loop_addr = idx[11:0] + 12'(cnt);
  assign v_rd      = v[v_ra];
  assign frame_rd  = frame[frame_ra];
  assign shsrc     = shift_vy ? vy_q : vx_q;

  // Sprite byte placed at the left edge, then rotated right by the start column.
  assign sprite   = {mem_rd, 56'h0};
  assign rot      = {sprite, sprite} >> vx_q[5:0];
  assign mask     = rot[63:0];
  assign overlap  = frame_rd & mask;
  assign last_row = (cnt[3:0] == n - 4'd1);

  // Digits of Vx: hundreds by compare, tens by reciprocal multiply of the remainder.
  always_comb begin
    if (vx_q >= 8'd200) begin
      bcd_h   = 4'd2;
      bcd_rem = vx_q - 8'd200;
    end else if (vx_q >= 8'd100) begin
      bcd_h   = 4'd1;
      bcd_rem = vx_q - 8'd100;
    end else begin
      bcd_h   = 4'd0;
      bcd_rem = vx_q;
    end
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - ({4'd0, bcd_t} << 3) - ({4'd0, bcd_t} << 1));
  end

  c8x_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rd)
  );

  c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (pc),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  c8x_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:  if (init_cnt == 12'hFFF) state_next = S_IDLE;
      S_IDLE: begin
        if (items.valid) begin
          unique case (op_t'(items.data.operation))
            OP_LOAD:     state_next = S_DONE;
            OP_EXEC:     state_next = S_F0;
            OP_READ_ROW: state_next = S_ROW;
            OP_UNUSED:   state_next = S_DONE;
          endcase
        end
      end
      S_F0:    state_next = S_F1;
      S_F1:    state_next = S_F2;
      S_F2:    state_next = S_RX;
      S_RX:    state_next = S_RY;
      S_RY:    state_next = S_EXEC;
      S_EXEC: begin
        state_next = S_DONE;
        if (word_q == INSN_CLS) begin
          state_next = S_CLR;
        end else if (word_q == INSN_RET && sp != '0) begin
          state_next = S_RET;
        end else if (opc == OPC_DRW && n != 4'd0) begin
          state_next = S_DRAWA;
        end else if (opc == OPC_MISC && nn == FX_BCD) begin
          state_next = S_BCD;
        end else if (opc == OPC_MISC && nn == FX_STORE) begin
          state_next = S_STORE;
        end else if (opc == OPC_MISC && nn == FX_LOAD) begin
          state_next = S_LOADA;
        end
      end
      S_RET:   state_next = S_DONE;
      S_CLR:   if (cnt == 5'd31) state_next = S_DONE;
      S_DRAWA: state_next = S_DRAWB;
      S_DRAWB: state_next = last_row ? S_DONE : S_DRAWA;
      S_BCD:   if (cnt == 5'd2) state_next = S_DONE;
      S_STORE: if (cnt[3:0] == x) state_next = S_DONE;
      S_LOADA: state_next = S_LOADB;
      S_LOADB: state_next = (cnt[3:0] == x) ? S_DONE : S_LOADA;
      S_ROW:   state_next = S_DONE;
      S_DONE:  if (!out_valid || results.ready) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  // Memory, register-file, display, stack and ALU controls for each step.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = loop_addr;
    mem_wdata = 8'h00;
    mem_raddr = loop_addr;
    v_ra      = cnt[3:0];
    frame_ra  = cnt;
    stk_we    = 1'b0;
    stk_waddr = SAW'(sp);
    stk_raddr = SAW'(sp - SPW'(1));
    alu_req   = '{op: ALU_PASS, a: vx_q, b: nn};
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt;
        mem_wdata = font_byte(init_cnt);
      end
      S_IDLE: begin
        mem_we    = items.valid && (items.data.operation == OP_LOAD);
        mem_waddr = items.data.mem_address;
        mem_wdata = items.data.mem_data;
      end
      S_F0: mem_raddr = pc;
      S_F1: mem_raddr = pc + 12'd1;
      S_RX: v_ra = x;
      S_RY: v_ra = y;
      S_EXEC: begin
        stk_we = (opc == OPC_CALL) && (sp < SP_FULL);
        priority case (opc)
          OPC_SEV, OPC_SNEV: alu_req = '{op: ALU_PASS, a: vx_q, b: vy_q};
          OPC_ADD:           alu_req = '{op: ALU_ADD, a: vx_q, b: nn};
          OPC_RND:           alu_req = '{op: ALU_AND, a: rnd_q, b: nn};
          OPC_ALU: begin
            priority case (n)
              A8_MOV:  alu_req = '{op: ALU_PASS, a: vx_q, b: vy_q};
              A8_OR:   alu_req = '{op: ALU_OR,   a: vx_q, b: vy_q};
              A8_AND:  alu_req = '{op: ALU_AND,  a: vx_q, b: vy_q};
              A8_XOR:  alu_req = '{op: ALU_XOR,  a: vx_q, b: vy_q};
              A8_ADD:  alu_req = '{op: ALU_ADD,  a: vx_q, b: vy_q};
              A8_SUB:  alu_req = '{op: ALU_SUB,  a: vx_q, b: vy_q};
              A8_RSB:  alu_req = '{op: ALU_SUB,  a: vy_q, b: vx_q};
              A8_SHR:  alu_req = '{op: ALU_SHR,  a: shsrc, b: vy_q};
              A8_SHL:  alu_req = '{op: ALU_SHL,  a: shsrc, b: vy_q};
              default: alu_req = '{op: ALU_PASS, a: vx_q, b: vy_q};
            endcase
          end
          default: alu_req = '{op: ALU_PASS, a: vx_q, b: nn};
        endcase
      end
      S_DRAWB: frame_ra = vy_q[4:0] + cnt;
      S_BCD: begin
        mem_we = 1'b1;
        if (cnt == 5'd0) begin
          mem_wdata = {4'd0, bcd_q[11:8]};
        end else if (cnt == 5'd1) begin
          mem_wdata = {4'd0, bcd_q[7:4]};
        end else begin
          mem_wdata = {4'd0, bcd_q[3:0]};
        end
      end
      S_STORE: begin
        mem_we    = 1'b1;
        mem_wdata = v_rd;
      end
      S_ROW: frame_ra = rowsel_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      pc        <= START_PC;
      idx       <= '0;
      sp        <= '0;
      dt        <= '0;
      shift_vy  <= 1'b1;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) v[i] <= '0;
      for (int r = 0; r < 32; r++) frame[r] <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) shift_vy <= cfg.data.shift_copies_vy;
      if (state == S_DONE && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: init_cnt <= init_cnt + 12'd1;
        S_IDLE: begin
          if (items.valid) begin
            rnd_q    <= items.data.random_byte;
            rowsel_q <= items.data.row_select;
            word_q   <= '0;
            row_q    <= '0;
            changed  <= 1'b0;
            serr     <= 1'b0;
          end
        end
        S_F1: word_q[15:8] <= mem_rd;
        S_F2: begin
          word_q[7:0] <= mem_rd;
          pc          <= pc + 12'd2;
        end
        S_RX: vx_q <= v_rd;
        S_RY: vy_q <= v_rd;
        S_EXEC: begin
          cnt <= '0;
          hit <= 1'b0;
          priority case (opc)
            OPC_SYS: begin
              if (word_q == INSN_RET) begin
                if (sp == '0) serr <= 1'b1;
                else sp <= sp - SPW'(1);
              end
            end
            OPC_JP: pc <= nnn;
            OPC_CALL: begin
              if (sp < SP_FULL) sp <= sp + SPW'(1);
              else serr <= 1'b1;
              pc <= nnn;
            end
            OPC_SE, OPC_SEV:   if (alu_rsp.eq) pc <= pc + 12'd2;
            OPC_SNE, OPC_SNEV: if (!alu_rsp.eq) pc <= pc + 12'd2;
            OPC_LD:            v[x] <= nn;
            OPC_ADD, OPC_RND:  v[x] <= alu_rsp.res;
            OPC_ALU: begin
              priority case (n)
                A8_MOV, A8_OR, A8_AND, A8_XOR: v[x] <= alu_rsp.res;
                A8_ADD, A8_SUB, A8_RSB, A8_SHR, A8_SHL: begin
                  // The flag takes precedence when X is VF.
                  if (x != VF_IDX) v[x] <= alu_rsp.res;
                  v[VF_IDX] <= {7'd0, alu_rsp.flag};
                end
                default: ;
              endcase
            end
            OPC_LDI: idx <= {4'd0, nnn};
            OPC_JPV: pc  <= nnn + {4'd0, v[0]};
            OPC_DRW: if (n == 4'd0) v[VF_IDX] <= 8'd0;
            OPC_MISC: begin
              priority case (nn)
                FX_GET_DT: v[x] <= dt;
                FX_SET_DT: dt   <= vx_q;
                FX_ADD_I:  idx  <= idx + {8'd0, vx_q};
                FX_FONT:   idx  <= {4'd0, FONT_BASE} + {10'd0, vx_q[3:0], 2'b00}
                                   + {12'd0, vx_q[3:0]};
                FX_BCD:    bcd_q <= {bcd_h, bcd_t, bcd_o};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_RET: pc <= stk_rd;
        S_CLR: begin
          if (frame_rd != '0) changed <= 1'b1;
          frame[frame_ra] <= '0;
          cnt <= cnt + 5'd1;
        end
        S_DRAWB: begin
          if (overlap != '0) hit <= 1'b1;
          if (mask != '0) changed <= 1'b1;
          frame[frame_ra] <= frame_rd ^ mask;
          cnt <= cnt + 5'd1;
          if (last_row) v[VF_IDX] <= {7'd0, hit | (overlap != '0)};
        end
        S_BCD, S_STORE: cnt <= cnt + 5'd1;
        S_LOADB: begin
          v[cnt[3:0]] <= mem_rd;
          cnt <= cnt + 5'd1;
        end
        S_ROW: row_q <= frame_rd;
        S_DONE: begin
          if (!out_valid || results.ready) begin
            out_data.pc_after         <= pc;
            out_data.instruction_word <= word_q;
            out_data.flag_value       <= v[VF_IDX];
            out_data.screen_changed   <= changed;
            out_data.stack_error      <= serr;
            out_data.display_row      <= row_q;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/c8x_checker.sv]
// Port-level checks of the CHIP-8 executor and the bind that attaches them.
// Depends only on the ports of chip8_instruction_executor_unit.
module c8x_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] instruction_word,
  input logic        stack_error,
  input logic [63:0] display_row
);
  // A pending result word is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Every accepted item makes the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // Only a row read returns display data; it fetches no instruction.
  a_row_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && instruction_word != 16'h0 |-> display_row == 64'h0)
    else $error("display row on an instruction result");

  // A stack error comes only from a call or a return.
  a_stack_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && stack_error |->
      (instruction_word[15:12] == 4'h2 || instruction_word == 16'h00EE))
    else $error("stack error on an unrelated instruction");
endmodule

bind chip8_instruction_executor_unit c8x_checker u_c8x_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (items.valid),
  .in_ready         (items.ready),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .instruction_word (results.data.instruction_word),
  .stack_error      (results.data.stack_error),
  .display_row      (results.data.display_row)
);
